// ===== rtl/core/rdsf_pkg.sv =====
package rdsf_pkg;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 8;
  localparam int unsigned FrameW = 16;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned PctW   = 7;
  localparam int unsigned OpW    = 3;

  localparam logic [AddrW-1:0] ADDR_HSLS    = 5'h01;
  localparam logic [AddrW-1:0] ADDR_INRUSH  = 5'h04;
  localparam logic [AddrW-1:0] ADDR_SWITCH  = 5'h06;
  localparam logic [AddrW-1:0] ADDR_MAP_ALL = 5'h09;
  localparam logic [AddrW-1:0] ADDR_MAP_LED = 5'h0A;
  localparam logic [AddrW-1:0] ADDR_DUTY_G  = 5'h0B;
  localparam logic [AddrW-1:0] ADDR_DUTY_L  = 5'h0C;

  localparam logic [DataW-1:0] HIGH_SIDE_RESET = 8'h03;
  localparam logic [PctW-1:0]  PCT_MAX         = 7'd100;

  typedef enum logic [OpW-1:0] {
    OP_SWITCH = 3'd0,
    OP_DUTY   = 3'd1,
    OP_MAP    = 3'd2,
    OP_SIDE   = 3'd3,
    OP_INRUSH = 3'd4
  } op_e;

  // one or two frames worth of address and data, or a reject
  typedef struct packed {
    logic             rej;
    logic             two;
    logic [AddrW-1:0] addr0;
    logic [DataW-1:0] data0;
    logic [AddrW-1:0] addr1;
    logic [DataW-1:0] data1;
  } pair_t;

  function automatic logic [FrameW-1:0] make_frame(input logic [AddrW-1:0] addr,
                                                    input logic [DataW-1:0] data,
                                                    input logic             tog);
    logic par;
    par = ~(^{1'b1, addr, data});
    return {1'b1, addr, data, par, tog};
  endfunction

endpackage

// ===== rtl/core/rdsf_decode.sv =====
module rdsf_decode (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rdsf_pkg::OpW-1:0]     op_i,
  input  logic [rdsf_pkg::ChanW-1:0]   chan_i,
  input  logic                         enable_i,
  input  logic                         use_general_i,
  input  logic                         use_led_i,
  input  logic [rdsf_pkg::PctW-1:0]    duty_percent_i,
  output logic                         pair_valid_o,
  input  logic                         pair_ready_i,
  output rdsf_pkg::pair_t              pair_o
);
  import rdsf_pkg::*;

  // floor(x/100) as (x*Recip) >> RecipSh, exact for x up to 25500
  localparam logic [12:0] Recip   = 13'd5243;
  localparam int unsigned RecipSh = 19;

  logic [DataW-1:0] on_q, on_d, hs_q, hs_d, gen_q, gen_d, led_q, led_d, inr_q, inr_d;
  logic             pair_valid_q, pair_valid_d;
  pair_t            pair_q, pair_d;

  logic [DataW-1:0] bit_sel;
  logic             bad_ch;
  logic             produce;
  logic             accept;
  logic [PctW-1:0]  pct_c;
  logic [14:0]      scaled;
  logic [27:0]      prod;
  logic [DataW-1:0] duty_val;

  assign bit_sel = DataW'(1) << chan_i[2:0];
  assign bad_ch  = chan_i[3];

  assign pct_c    = (duty_percent_i > PCT_MAX) ? PCT_MAX : duty_percent_i;
  assign scaled   = {pct_c, 8'b0} - 15'(pct_c);
  assign prod     = 28'(scaled) * 28'(Recip);
  assign duty_val = prod[RecipSh+DataW-1:RecipSh];

  assign in_ready_o = !pair_valid_q || pair_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    on_d    = on_q;
    hs_d    = hs_q;
    gen_d   = gen_q;
    led_d   = led_q;
    inr_d   = inr_q;
    produce = 1'b1;
    pair_d  = '0;
    case (op_i)
      OP_SWITCH: begin
        if (bad_ch) begin
          pair_d.rej = 1'b1;
        end else begin
          on_d         = enable_i ? (on_q | bit_sel) : (on_q & ~bit_sel);
          pair_d.addr0 = ADDR_SWITCH;
          pair_d.data0 = on_d;
        end
      end
      OP_DUTY: begin
        // channel is ignored here
        produce      = use_general_i || use_led_i;
        pair_d.two   = use_general_i && use_led_i;
        pair_d.addr0 = use_general_i ? ADDR_DUTY_G : ADDR_DUTY_L;
        pair_d.data0 = duty_val;
        pair_d.addr1 = ADDR_DUTY_L;
        pair_d.data1 = duty_val;
      end
      OP_MAP: begin
        if (bad_ch || (use_general_i && use_led_i)) begin
          pair_d.rej = 1'b1;
        end else begin
          gen_d        = use_general_i ? (gen_q | bit_sel) : (gen_q & ~bit_sel);
          led_d        = use_led_i ? (led_q | bit_sel) : (led_q & ~bit_sel);
          pair_d.two   = 1'b1;
          pair_d.addr0 = ADDR_MAP_ALL;
          pair_d.data0 = gen_d | led_d;
          pair_d.addr1 = ADDR_MAP_LED;
          pair_d.data1 = led_d;
        end
      end
      OP_SIDE: begin
        // channels 0 and 1 are high side only
        if (bad_ch || (chan_i[3:1] == 3'b000 && !enable_i)) begin
          pair_d.rej = 1'b1;
        end else begin
          hs_d         = enable_i ? (hs_q | bit_sel) : (hs_q & ~bit_sel);
          pair_d.addr0 = ADDR_HSLS;
          pair_d.data0 = hs_d;
        end
      end
      OP_INRUSH: begin
        if (bad_ch) begin
          pair_d.rej = 1'b1;
        end else begin
          inr_d        = enable_i ? (inr_q | bit_sel) : (inr_q & ~bit_sel);
          pair_d.addr0 = ADDR_INRUSH;
          pair_d.data0 = inr_d;
        end
      end
      default: begin
        pair_d.rej = 1'b1;
      end
    endcase
  end

  always_comb begin
    pair_valid_d = pair_valid_q;
    if (accept) begin
      pair_valid_d = produce;
    end else if (pair_ready_i) begin
      pair_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q         <= '0;
      hs_q         <= HIGH_SIDE_RESET;
      gen_q        <= '0;
      led_q        <= '0;
      inr_q        <= '0;
      pair_valid_q <= 1'b0;
    end else begin
      pair_valid_q <= pair_valid_d;
      if (accept) begin
        on_q  <= on_d;
        hs_q  <= hs_d;
        gen_q <= gen_d;
        led_q <= led_d;
        inr_q <= inr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pair_q <= pair_d;
    end
  end

  assign pair_valid_o = pair_valid_q;
  assign pair_o       = pair_q;

  // a held pair must not change until the serialiser takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_valid_q && !pair_ready_i |=> pair_valid_q && $stable(pair_q))
    else $error("pending pair overwritten");

  // low side must never be set on channels 0 and 1
  assert property (@(posedge clk_i) disable iff (!rst_ni) hs_q[1:0] == 2'b11)
    else $error("channel 0 or 1 left on low side");

endmodule

// ===== rtl/core/rdsf_serialiser.sv =====
module rdsf_serialiser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pair_valid_i,
  output logic                          pair_ready_o,
  input  rdsf_pkg::pair_t               pair_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rdsf_pkg::FrameW-1:0]   frame_o,
  output logic                          last_o,
  output logic                          rej_o
);
  import rdsf_pkg::*;

  logic  busy_q, busy_d;
  logic  idx_q, idx_d;
  logic  tog_q, tog_d;
  pair_t pair_q;
  logic  out_fire;
  logic  load;

  assign out_valid_o  = busy_q;
  assign rej_o        = pair_q.rej;
  assign last_o       = pair_q.rej || !pair_q.two || idx_q;
  assign frame_o      = pair_q.rej ? '0 :
                        idx_q ? make_frame(pair_q.addr1, pair_q.data1, tog_q) :
                                make_frame(pair_q.addr0, pair_q.data0, tog_q);

  assign out_fire     = busy_q && out_ready_i;
  assign pair_ready_o = !busy_q || (out_fire && last_o);
  assign load         = pair_valid_i && pair_ready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    tog_d  = tog_q;
    if (out_fire) begin
      // the toggle flips only on real frames
      if (!pair_q.rej) begin
        tog_d = ~tog_q;
      end
      if (last_o) begin
        busy_d = 1'b0;
      end else begin
        idx_d = 1'b1;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      idx_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 1'b0;
      tog_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      tog_q  <= tog_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pair_q <= pair_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_fire && !pair_q.rej) |=> $stable(tog_q))
    else $error("frame toggle moved without a frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && pair_q.rej |-> frame_o == '0 && last_o)
    else $error("rejected beat not a single zero frame");

endmodule

// ===== rtl/core/relay_driver_spi_command_framer_unit.sv =====
// Command framer for an eight-channel low-side/high-side output driver.
// s_axis carries one channel command per beat: tuser is the operation,
// tdata the channel, flags and duty percent. m_axis carries 16-bit SPI
// write frames, one or two per command; tlast marks the final frame of a
// command and tuser flags a rejected command, whose single frame is zero.
// A duty command with no generator selected gives no beat at all.
// A command accepted on s_axis is registered by the decode stage, then
// loaded into the serialiser, which presents its first frame on m_axis.
// Throughput: one command per cycle when it yields one frame and the
// receiver is ready; the output channel moves one frame per cycle while
// m_axis_tready is high, so the frame count sets the rate.
// The decode stage holds one command while the serialiser emits, so input
// keeps flowing while a finished frame waits for the receiver. When the
// receiver stalls, frames and tlast hold and the input stalls once both
// stages are full. Reset clears all shadow masks except the high-side
// mask (channels 0 and 1 high side) and the frame toggle starts at zero.
module relay_driver_spi_command_framer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel[3:0], enable[4], use_general[5], use_led[6], duty_percent[13:7], zero[15:14]
  input  logic [15:0] s_axis_tdata,
  // operation[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame[15:0]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // rejected[0]
  output logic        m_axis_tuser
);
  import rdsf_pkg::*;

  logic  pair_valid;
  logic  pair_ready;
  pair_t pair;

  rdsf_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .op_i           (s_axis_tuser),
    .chan_i         (s_axis_tdata[3:0]),
    .enable_i       (s_axis_tdata[4]),
    .use_general_i  (s_axis_tdata[5]),
    .use_led_i      (s_axis_tdata[6]),
    .duty_percent_i (s_axis_tdata[13:7]),
    .pair_valid_o   (pair_valid),
    .pair_ready_i   (pair_ready),
    .pair_o         (pair)
  );

  rdsf_serialiser u_serialiser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_valid_i (pair_valid),
    .pair_ready_o (pair_ready),
    .pair_i       (pair),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .frame_o      (m_axis_tdata),
    .last_o       (m_axis_tlast),
    .rej_o        (m_axis_tuser)
  );

endmodule
